// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

    // fixed field widths
    localparam int ADDR_W    = 48;
    localparam int START_W   = ADDR_W + 1;
    localparam int BASE_W    = 36;
    localparam int PFN_W     = BASE_W + 1;
    localparam int COUNT_W   = 13;
    localparam int ORD_W     = 6;
    localparam int TAG_W     = ORD_W + 1;
    localparam int FREE_POS  = ORD_W;

    // defaults for the top-level parameters
    localparam int DEF_POOL_PAGES      = 4096;
    localparam int DEF_MAX_ORDER_COUNT = 32;
    localparam int DEF_PAGE_SHIFT      = 12;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BASE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'd1;

    // request kinds
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_ADD   = 2'd2;

    // result status
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK  = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd2;
    localparam logic [OP_W-1:0] OP_A_ORDER   = 5'd3;
    localparam logic [OP_W-1:0] OP_A_PICK    = 5'd4;
    localparam logic [OP_W-1:0] OP_A_POP     = 5'd5;
    localparam logic [OP_W-1:0] OP_A_SPLIT   = 5'd6;
    localparam logic [OP_W-1:0] OP_A_DONE    = 5'd7;
    localparam logic [OP_W-1:0] OP_F_LOOK    = 5'd8;
    localparam logic [OP_W-1:0] OP_F_TAG     = 5'd9;
    localparam logic [OP_W-1:0] OP_F_BUDDY   = 5'd10;
    localparam logic [OP_W-1:0] OP_RM_START  = 5'd11;
    localparam logic [OP_W-1:0] OP_RM_READ   = 5'd12;
    localparam logic [OP_W-1:0] OP_RM_STEP   = 5'd13;
    localparam logic [OP_W-1:0] OP_RM_UNLINK = 5'd14;
    localparam logic [OP_W-1:0] OP_F_MERGE   = 5'd15;
    localparam logic [OP_W-1:0] OP_F_DONE    = 5'd16;
    localparam logic [OP_W-1:0] OP_D_EVAL    = 5'd17;
    localparam logic [OP_W-1:0] OP_D_STEP    = 5'd18;
    localparam logic [OP_W-1:0] OP_D_CAP     = 5'd19;
    localparam logic [OP_W-1:0] OP_D_SKIP    = 5'd20;
    localparam logic [OP_W-1:0] OP_D_PUT     = 5'd21;
    localparam logic [OP_W-1:0] OP_FINISH    = 5'd22;
    localparam logic [OP_W-1:0] OP_EMIT      = 5'd23;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] byte_count;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic [ORD_W-1:0]  granted_order;
    } res_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       too_large;
        logic       no_block;
        logic       split_more;
        logic       in_pool;
        logic       tag_bad;
        logic       merge_ok;
        logic       buddy_in;
        logic       tag_match;
        logic       mask_bit;
        logic       walk_live;
        logic       walk_hit;
        logic       add_more;
        logic       bit_small;
        logic       beyond;
        logic       skip;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/bpa_datapath.sv =====
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES      = DEF_POOL_PAGES,
    parameter int MAX_ORDER_COUNT = DEF_MAX_ORDER_COUNT,
    parameter int PAGE_SHIFT      = DEF_PAGE_SHIFT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  req_t                  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output res_t                  out_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW   = $clog2(POOL_PAGES);
    localparam int IW   = $clog2(POOL_PAGES + 1);
    localparam int MOW  = $clog2(MAX_ORDER_COUNT);
    localparam int CAP  = MAX_ORDER_COUNT - 1;
    localparam int LO_W = BASE_W + PAGE_SHIFT;
    localparam int DW   = (LO_W > START_W) ? LO_W : START_W;
    localparam logic [IW-1:0] LINK_END = IW'(POOL_PAGES);

    // configuration
    logic [BASE_W-1:0]  base_reg;
    logic [COUNT_W-1:0] count_reg;

    // item and walk registers
    logic [1:0]         kind_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic [START_W-1:0] start_reg;
    logic [ORD_W-1:0]   order_reg;
    logic [ORD_W-1:0]   cur_reg;
    logic [ORD_W-1:0]   bit_reg;
    logic               big_reg;
    logic               empty_reg;
    logic               top_ok_reg;
    logic               inpool_reg;
    logic               bin_reg;
    logic [PFN_W-1:0]   pfn_reg;
    logic [PFN_W-1:0]   bpfn_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      bidx_reg;
    logic [IW-1:0]      walk_cur_reg;
    logic [IW-1:0]      walk_prev_reg;
    logic [IW-1:0]      steps_reg;
    logic [DW-1:0]      diff_reg;
    logic               borrow_reg;
    logic [AW-1:0]      clr_reg;
    res_t               res_reg;
    res_t               out_item_reg;
    logic               out_valid_reg;

    // free lists
    logic [IW-1:0]              head_reg [MAX_ORDER_COUNT];
    logic [MAX_ORDER_COUNT-1:0] mask_reg;

    // page stores
    logic [TAG_W-1:0] tag_mem  [POOL_PAGES];
    logic [IW-1:0]    link_mem [POOL_PAGES];
    logic [TAG_W-1:0] tag_rd_reg;
    logic [IW-1:0]    link_rd_reg;

    // {hit, index} of a page frame number inside the pool
    function automatic logic [IW:0] page_of(input logic [START_W-1:0] pfn,
                                            input logic [BASE_W-1:0]  base,
                                            input logic [COUNT_W-1:0] cnt);
        logic [START_W:0]   d;
        logic [START_W-1:0] trk;
        logic               hit;
        d   = {1'b0, pfn} - {1'b0, START_W'(base)};
        trk = (START_W'(cnt) < START_W'(POOL_PAGES)) ? START_W'(cnt)
                                                      : START_W'(POOL_PAGES);
        hit = !d[START_W] && (d[START_W-1:0] < trk);
        return {hit, IW'(d[START_W-1:0])};
    endfunction

    // {beyond range, buddy pfn}
    function automatic logic [START_W:0] buddy_of(input logic [PFN_W-1:0] pfn,
                                                  input logic [ORD_W-1:0] ord);
        logic [ORD_W-1:0] sh;
        logic             far;
        sh  = ord - ORD_W'(PAGE_SHIFT);
        far = (sh >= ORD_W'(START_W));
        return {far, START_W'(pfn) ^ (START_W'(1) << sh)};
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PFN_W-1:0] pfn);
        logic [PFN_W+PAGE_SHIFT-1:0] a;
        a = {pfn, {PAGE_SHIFT{1'b0}}};
        return ADDR_W'(a);
    endfunction

    // ---------------- combinational helpers ----------------
    logic [ORD_W-1:0]           flog;
    logic [ORD_W:0]             ceil_ord;
    logic [ORD_W-1:0]           alloc_ord;
    logic [MAX_ORDER_COUNT-1:0] hi_mask;
    logic [ORD_W-1:0]           pick;
    logic [IW-1:0]              top;
    logic [ORD_W-1:0]           split_ord;
    logic [START_W:0]           split_b;
    logic [IW:0]                split_pg;
    logic                       split_hit;
    logic [START_W:0]           free_b;
    logic [IW:0]                free_bpg;
    logic [IW:0]                look_pg;
    logic [IW:0]                start_pg;
    logic [ORD_W:0]             low_s;
    logic [ORD_W-1:0]           add_bit;
    logic [START_W-1:0]         step;
    logic [START_W-1:0]         pool_end;
    logic [DW:0]                diff_c;
    logic [DW-1:0]              size_hi;
    logic [DW-1:0]              diff_hi;
    logic [DW-1:0]              skip_n;

    always_comb
    begin
        flog = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (size_reg[i])
            begin
                flog = ORD_W'(i);
            end
        end
        ceil_ord = {1'b0, flog}
                 + {{ORD_W{1'b0}}, ((size_reg & (size_reg - 1'b1)) != '0)};
        alloc_ord = (ceil_ord < (ORD_W+1)'(PAGE_SHIFT)) ? ORD_W'(PAGE_SHIFT)
                                                        : ORD_W'(ceil_ord);

        hi_mask = mask_reg & ~((MAX_ORDER_COUNT'(1) << order_reg) - 1'b1);
        pick = '0;
        for (int i = MAX_ORDER_COUNT - 1; i >= 0; i--)
        begin
            if (hi_mask[i])
            begin
                pick = ORD_W'(i);
            end
        end
        top = head_reg[pick[MOW-1:0]];

        split_ord = cur_reg - 1'b1;
        split_b   = buddy_of(pfn_reg, split_ord);
        split_pg  = page_of(split_b[START_W-1:0], base_reg, count_reg);
        split_hit = !split_b[START_W] && split_pg[IW];

        free_b   = buddy_of(pfn_reg, order_reg);
        free_bpg = page_of(free_b[START_W-1:0], base_reg, count_reg);

        look_pg  = page_of(start_reg >> PAGE_SHIFT, base_reg, count_reg);
        start_pg = look_pg;

        // lowest set bit of the range start; zero is aligned to everything
        low_s = (ORD_W+1)'(64);
        for (int i = START_W - 1; i >= 0; i--)
        begin
            if (start_reg[i])
            begin
                low_s = (ORD_W+1)'(i);
            end
        end
        add_bit = (low_s < {1'b0, flog}) ? ORD_W'(low_s) : flog;
        step    = START_W'(1) << bit_reg;

        pool_end = START_W'(base_reg)
                 + ((START_W'(count_reg) < START_W'(POOL_PAGES)) ? START_W'(count_reg)
                                                                : START_W'(POOL_PAGES));
        diff_c  = {1'b0, DW'(base_reg) << PAGE_SHIFT} - {1'b0, DW'(start_reg)};
        size_hi = (DW'(size_reg) >> CAP) << CAP;
        diff_hi = (diff_reg >> CAP) << CAP;
        skip_n  = (size_hi < diff_hi) ? size_hi : diff_hi;
    end

    // ---------------- store port selection ----------------
    logic              tag_we, tag_re, link_we, link_re, push_en;
    logic [IW-1:0]     tag_wa, tag_ra, link_wa, link_ra, push_idx;
    logic [TAG_W-1:0]  tag_wd;
    logic [IW-1:0]     link_wd;
    logic [ORD_W-1:0]  push_ord;

    always_comb
    begin
        tag_we   = 1'b0;
        tag_wa   = idx_reg;
        tag_wd   = '0;
        tag_re   = 1'b0;
        tag_ra   = idx_reg;
        link_re  = 1'b0;
        link_ra  = walk_cur_reg;
        push_en  = 1'b0;
        push_ord = order_reg;
        push_idx = idx_reg;
        link_we  = 1'b0;
        link_wa  = walk_prev_reg;
        link_wd  = link_rd_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                tag_we = 1'b1;
                tag_wa = IW'(clr_reg);
            end
            OP_A_PICK:
            begin
                link_re = 1'b1;
                link_ra = top;
            end
            OP_A_SPLIT:
            begin
                push_en  = split_hit;
                push_ord = split_ord;
                push_idx = split_pg[IW-1:0];
                tag_we   = split_hit;
                tag_wa   = split_pg[IW-1:0];
                tag_wd   = {1'b1, split_ord};
            end
            OP_A_DONE:
            begin
                tag_we = 1'b1;
                tag_wd = {1'b0, order_reg};
            end
            OP_F_LOOK:
            begin
                tag_re = look_pg[IW];
                tag_ra = look_pg[IW-1:0];
            end
            OP_F_BUDDY:
            begin
                tag_re = !free_b[START_W] && free_bpg[IW];
                tag_ra = free_bpg[IW-1:0];
            end
            OP_RM_READ:
            begin
                link_re = 1'b1;
            end
            OP_RM_UNLINK:
            begin
                link_we = (walk_prev_reg != LINK_END);
            end
            OP_F_MERGE:
            begin
                tag_we = 1'b1;
                tag_wa = (bpfn_reg < pfn_reg) ? idx_reg : bidx_reg;
            end
            OP_F_DONE:
            begin
                push_en = 1'b1;
                tag_we  = 1'b1;
                tag_wd  = {1'b1, order_reg};
            end
            OP_D_PUT:
            begin
                push_en  = start_pg[IW];
                push_ord = bit_reg;
                push_idx = start_pg[IW-1:0];
                tag_we   = start_pg[IW];
                tag_wa   = start_pg[IW-1:0];
                tag_wd   = {1'b1, bit_reg};
            end
            default:
            begin
            end
        endcase
        if (push_en)
        begin
            link_we = 1'b1;
            link_wa = push_idx;
            link_wd = mask_reg[push_ord[MOW-1:0]] ? head_reg[push_ord[MOW-1:0]] : LINK_END;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa[AW-1:0]] <= tag_wd;
        end
        if (tag_re)
        begin
            tag_rd_reg <= tag_mem[tag_ra[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa[AW-1:0]] <= link_wd;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_ra[AW-1:0]];
        end
    end

    // ---------------- list heads ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ORDER_COUNT; i++)
            begin
                head_reg[i] <= LINK_END;
            end
            mask_reg <= '0;
        end
        else
        begin
            if (push_en)
            begin
                head_reg[push_ord[MOW-1:0]] <= push_idx;
                mask_reg[push_ord[MOW-1:0]] <= 1'b1;
            end
            if (cmd.op == OP_A_POP)
            begin
                if (!top_ok_reg || link_rd_reg >= LINK_END)
                begin
                    head_reg[cur_reg[MOW-1:0]] <= LINK_END;
                    mask_reg[cur_reg[MOW-1:0]] <= 1'b0;
                end
                else
                begin
                    head_reg[cur_reg[MOW-1:0]] <= link_rd_reg;
                end
            end
            if (cmd.op == OP_RM_UNLINK && walk_prev_reg == LINK_END)
            begin
                if (link_rd_reg >= LINK_END)
                begin
                    head_reg[order_reg[MOW-1:0]] <= LINK_END;
                    mask_reg[order_reg[MOW-1:0]] <= 1'b0;
                end
                else
                begin
                    head_reg[order_reg[MOW-1:0]] <= link_rd_reg;
                end
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_POOL_BASE:  base_reg  <= cfg_data[BASE_W-1:0];
                    CFG_POOL_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                kind_reg  <= in_item.req_type;
                size_reg  <= in_item.byte_count;
                start_reg <= START_W'(in_item.block_address);
            end
            OP_A_ORDER:
            begin
                order_reg <= alloc_ord;
                big_reg   <= ({1'b0, alloc_ord} >= (ORD_W+1)'(MAX_ORDER_COUNT));
            end
            OP_A_PICK:
            begin
                cur_reg    <= pick;
                empty_reg  <= (hi_mask == '0);
                top_ok_reg <= (top < LINK_END);
                idx_reg    <= (top < LINK_END) ? top : '0;
            end
            OP_A_POP:
            begin
                pfn_reg <= PFN_W'(base_reg) + PFN_W'(idx_reg);
            end
            OP_A_SPLIT:
            begin
                cur_reg <= split_ord;
            end
            OP_A_DONE:
            begin
                res_reg <= '{status: ST_DONE, granted_address: addr_of(pfn_reg),
                             granted_order: order_reg};
            end
            OP_F_LOOK:
            begin
                inpool_reg <= look_pg[IW];
                idx_reg    <= look_pg[IW-1:0];
                pfn_reg    <= PFN_W'(start_reg >> PAGE_SHIFT);
            end
            OP_F_TAG:
            begin
                order_reg <= tag_rd_reg[ORD_W-1:0];
            end
            OP_F_BUDDY:
            begin
                bin_reg  <= !free_b[START_W] && free_bpg[IW];
                bidx_reg <= free_bpg[IW-1:0];
                bpfn_reg <= PFN_W'(free_b[START_W-1:0]);
            end
            OP_RM_START:
            begin
                walk_cur_reg  <= head_reg[order_reg[MOW-1:0]];
                walk_prev_reg <= LINK_END;
                steps_reg     <= '0;
            end
            OP_RM_STEP:
            begin
                walk_prev_reg <= walk_cur_reg;
                walk_cur_reg  <= link_rd_reg;
                steps_reg     <= steps_reg + 1'b1;
            end
            OP_F_MERGE:
            begin
                if (bpfn_reg < pfn_reg)
                begin
                    pfn_reg <= bpfn_reg;
                    idx_reg <= bidx_reg;
                end
                order_reg <= order_reg + 1'b1;
            end
            OP_F_DONE:
            begin
                res_reg <= '{status: ST_DONE, granted_address: addr_of(pfn_reg),
                             granted_order: order_reg};
            end
            OP_D_EVAL:
            begin
                bit_reg <= add_bit;
            end
            OP_D_STEP:
            begin
                start_reg <= start_reg + step;
                size_reg  <= size_reg - ADDR_W'(step);
            end
            OP_D_CAP:
            begin
                bit_reg    <= (bit_reg > ORD_W'(CAP)) ? ORD_W'(CAP) : bit_reg;
                diff_reg   <= diff_c[DW-1:0];
                borrow_reg <= diff_c[DW];
            end
            OP_D_SKIP:
            begin
                start_reg <= start_reg + START_W'(skip_n);
                size_reg  <= size_reg - ADDR_W'(skip_n);
            end
            OP_D_PUT:
            begin
                start_reg <= start_reg + step;
                size_reg  <= size_reg - ADDR_W'(step);
            end
            OP_FINISH:
            begin
                res_reg <= '{status: cmd.code, granted_address: '0, granted_order: '0};
            end
            OP_EMIT:
            begin
                out_item_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- status ----------------
    always_comb
    begin
        sts.kind       = kind_reg;
        sts.clr_last   = (clr_reg == AW'(POOL_PAGES - 1));
        sts.too_large  = big_reg;
        sts.no_block   = empty_reg;
        sts.split_more = (cur_reg > order_reg);
        sts.in_pool    = inpool_reg;
        sts.tag_bad    = (tag_rd_reg == '0) || tag_rd_reg[FREE_POS]
                      || ({1'b0, tag_rd_reg[ORD_W-1:0]} >= (ORD_W+1)'(MAX_ORDER_COUNT));
        sts.merge_ok   = (({1'b0, order_reg} + 1'b1) < (ORD_W+1)'(MAX_ORDER_COUNT));
        sts.buddy_in   = bin_reg;
        sts.tag_match  = (tag_rd_reg == {1'b1, order_reg});
        sts.mask_bit   = mask_reg[order_reg[MOW-1:0]];
        sts.walk_live  = (walk_cur_reg < LINK_END) && (steps_reg < LINK_END);
        sts.walk_hit   = (walk_cur_reg == bidx_reg);
        sts.add_more   = ((size_reg >> PAGE_SHIFT) != '0);
        sts.bit_small  = (bit_reg < ORD_W'(PAGE_SHIFT));
        sts.beyond     = ((start_reg >> PAGE_SHIFT) >= pool_end);
        sts.skip       = (bit_reg == ORD_W'(CAP)) && !borrow_reg && (diff_hi != '0);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |=> out_valid_reg)
        else $error("emitted result not shown");

    a_split_steps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_A_SPLIT |=> cur_reg == $past(cur_reg) - 1'b1)
        else $error("split did not lower the list order");

    a_walk_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RM_STEP |=> steps_reg == $past(steps_reg) + 1'b1)
        else $error("list walk step not counted");

endmodule

// ===== rtl/bpa_ctrl.sv =====
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_CLEAR   = 5'd0;
    localparam logic [SW-1:0] S_IDLE    = 5'd1;
    localparam logic [SW-1:0] S_KIND    = 5'd2;
    localparam logic [SW-1:0] S_A_CHK   = 5'd3;
    localparam logic [SW-1:0] S_A_POP   = 5'd4;
    localparam logic [SW-1:0] S_A_SPLIT = 5'd5;
    localparam logic [SW-1:0] S_F_TAG   = 5'd6;
    localparam logic [SW-1:0] S_F_LOOP  = 5'd7;
    localparam logic [SW-1:0] S_F_CHK   = 5'd8;
    localparam logic [SW-1:0] S_RM_RD   = 5'd9;
    localparam logic [SW-1:0] S_RM_CHK  = 5'd10;
    localparam logic [SW-1:0] S_F_MERGE = 5'd11;
    localparam logic [SW-1:0] S_D_LOOP  = 5'd12;
    localparam logic [SW-1:0] S_D_CHK   = 5'd13;
    localparam logic [SW-1:0] S_D_PUT   = 5'd14;
    localparam logic [SW-1:0] S_OUT     = 5'd15;

    logic [SW-1:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        cmd.code   = ST_DONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_KIND;
                end
            end
            S_KIND:
            begin
                unique case (sts.kind)
                    REQ_ALLOC:
                    begin
                        cmd.op     = OP_A_ORDER;
                        state_next = S_A_CHK;
                    end
                    REQ_FREE:
                    begin
                        cmd.op     = OP_F_LOOK;
                        state_next = S_F_TAG;
                    end
                    REQ_ADD:
                    begin
                        state_next = S_D_LOOP;
                    end
                    default:
                    begin
                        cmd.op     = OP_FINISH;
                        cmd.code   = ST_IGNORED;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_A_CHK:
            begin
                if (sts.too_large)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.code   = ST_TOO_LARGE;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_A_PICK;
                    state_next = S_A_POP;
                end
            end
            S_A_POP:
            begin
                if (sts.no_block)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.code   = ST_NO_BLOCK;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_A_POP;
                    state_next = S_A_SPLIT;
                end
            end
            S_A_SPLIT:
            begin
                if (sts.split_more)
                begin
                    cmd.op = OP_A_SPLIT;
                end
                else
                begin
                    cmd.op     = OP_A_DONE;
                    state_next = S_OUT;
                end
            end
            S_F_TAG:
            begin
                if (!sts.in_pool || sts.tag_bad)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.code   = ST_IGNORED;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_F_TAG;
                    state_next = S_F_LOOP;
                end
            end
            S_F_LOOP:
            begin
                if (sts.merge_ok)
                begin
                    cmd.op     = OP_F_BUDDY;
                    state_next = S_F_CHK;
                end
                else
                begin
                    cmd.op     = OP_F_DONE;
                    state_next = S_OUT;
                end
            end
            S_F_CHK:
            begin
                if (sts.buddy_in && sts.tag_match && sts.mask_bit)
                begin
                    cmd.op     = OP_RM_START;
                    state_next = S_RM_RD;
                end
                else
                begin
                    cmd.op     = OP_F_DONE;
                    state_next = S_OUT;
                end
            end
            S_RM_RD:
            begin
                if (sts.walk_live)
                begin
                    cmd.op     = OP_RM_READ;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    cmd.op     = OP_F_DONE;
                    state_next = S_OUT;
                end
            end
            S_RM_CHK:
            begin
                if (sts.walk_hit)
                begin
                    cmd.op     = OP_RM_UNLINK;
                    state_next = S_F_MERGE;
                end
                else
                begin
                    cmd.op     = OP_RM_STEP;
                    state_next = S_RM_RD;
                end
            end
            S_F_MERGE:
            begin
                cmd.op     = OP_F_MERGE;
                state_next = S_F_LOOP;
            end
            S_D_LOOP:
            begin
                if (sts.add_more)
                begin
                    cmd.op     = OP_D_EVAL;
                    state_next = S_D_CHK;
                end
                else
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_OUT;
                end
            end
            S_D_CHK:
            begin
                if (sts.bit_small)
                begin
                    cmd.op     = OP_D_STEP;
                    state_next = S_D_LOOP;
                end
                else if (sts.beyond)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_D_CAP;
                    state_next = S_D_PUT;
                end
            end
            S_D_PUT:
            begin
                cmd.op     = sts.skip ? OP_D_SKIP : OP_D_PUT;
                state_next = S_D_LOOP;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_KIND)
        else $error("accepted item not dispatched");

endmodule

// ===== rtl/buddy_page_allocator_top.sv =====
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_stall    in_item (req_t: req_type, byte_count, block_address)
// out       out  out_valid/out_stall  out_item (res_t: status, granted_address, granted_order)
// cfg       in   cfg_wr_en            cfg_index, cfg_data (0 pool base pfn, 1 pool page count)
//
// One item at a time. Allocate: order, pick, pop, then a split step per halving. Free: tag
// lookup, then per merge a buddy check and a walk of the buddy's free list (one link memory
// read per list entry visited). Add range: a loop of carve steps.
// After reset a clearing pass zeroes the tag memory; in_stall stays high until it ends.
// A result waits in an output register under out_stall while the next item is taken.
module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES      = DEF_POOL_PAGES,
    parameter int MAX_ORDER_COUNT = DEF_MAX_ORDER_COUNT,
    parameter int PAGE_SHIFT      = DEF_PAGE_SHIFT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  req_t                  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output res_t                  out_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // controller issues one datapath op per cycle, reads back status flags
    cmd_t cmd;
    sts_t sts;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tag and link memories, list heads, working registers, result register
    bpa_datapath #(
        .POOL_PAGES      (POOL_PAGES),
        .MAX_ORDER_COUNT (MAX_ORDER_COUNT),
        .PAGE_SHIFT      (PAGE_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== tb/buddy_page_allocator_top_tb.sv =====
`timescale 1ns / 1ps

// Buddy allocator testbench: a short table of directed requests, then random
// allocate/free/add traffic under several pool settings. Every item gives one
// result; each result is checked against an in-order software copy of the
// allocator kept in this module.
module buddy_page_allocator_top_tb;
    import bpa_pkg::*;

    localparam int    NPAGES  = DEF_POOL_PAGES;
    localparam int    NORDERS = DEF_MAX_ORDER_COUNT;
    localparam int    PSHIFT  = DEF_PAGE_SHIFT;
    localparam int    LIMIT   = 4000000;
    localparam int    SETTLE  = 64;   // idle cycles before a register write / the end

    typedef longint unsigned u64;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    req_t                  in_item;
    logic                  out_valid;
    logic                  out_stall;
    res_t                  out_item;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    buddy_page_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Allocator shadow: page tags, LIFO links, list heads, non-empty mask
    // ------------------------------------------------------------------
    bit [TAG_W-1:0] pg_tag  [NPAGES];
    int unsigned    pg_link [NPAGES];
    int unsigned    ord_head[NORDERS];
    u64             ord_mask;
    u64             pool_base;
    u64             pool_count;

    res_t           grant_q[$];    // results still owed by the block
    u64             held[$];       // addresses currently handed out
    int             errors;
    int             shown;
    int             cycles;
    int             burst_left;

    function automatic u64 tracked();
        return (pool_count < NPAGES) ? pool_count : NPAGES;
    endfunction

    function automatic bit page_index(input u64 a, output u64 idx);
        u64 pfn;
        pfn = a >> PSHIFT;
        idx = 0;
        if (pfn < pool_base) return 0;
        if (pfn - pool_base >= tracked()) return 0;
        idx = pfn - pool_base;
        return 1;
    endfunction

    function automatic u64 page_addr(input u64 idx);
        return (pool_base + idx) << PSHIFT;
    endfunction

    function automatic int floor_log2(input u64 v);
        int r;
        r = 0;
        while (v > 1) begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic int lowest_one(input u64 v);
        int r;
        r = 0;
        if (v == 0) return 64;
        while (v[0] == 1'b0) begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void push_block(input int order, input u64 idx);
        if (order >= NORDERS || idx >= NPAGES) return;
        pg_link[idx] = ord_mask[order] ? ord_head[order] : NPAGES;
        ord_head[order] = idx;
        ord_mask[order] = 1'b1;
    endfunction

    function automatic u64 pop_block(input int order);
        int unsigned top;
        int unsigned nxt;
        top = ord_head[order];
        nxt = (top < NPAGES) ? pg_link[top] : NPAGES;
        if (nxt >= NPAGES) begin
            ord_mask[order] = 1'b0;
            ord_head[order] = NPAGES;
        end
        else
            ord_head[order] = nxt;
        return (top < NPAGES) ? top : 0;
    endfunction

    function automatic bit unlink_block(input int order, input u64 idx);
        int unsigned prev;
        int unsigned cur;
        int          steps;
        prev = NPAGES;
        if (!ord_mask[order]) return 0;
        cur = ord_head[order];
        for (steps = 0; steps < NPAGES && cur < NPAGES; steps++)
        begin
            if (cur == idx)
            begin
                if (prev == NPAGES)
                begin
                    ord_head[order] = pg_link[cur];
                    if (ord_head[order] >= NPAGES)
                    begin
                        ord_head[order] = NPAGES;
                        ord_mask[order] = 1'b0;
                    end
                end
                else
                    pg_link[prev] = pg_link[cur];
                return 1;
            end
            prev = cur;
            cur  = pg_link[cur];
        end
        return 0;
    endfunction

    function automatic void release_block(input u64 a, input int order);
        u64 idx;
        if (!page_index(a, idx)) return;
        push_block(order, idx);
        pg_tag[idx] = {1'b1, order[ORD_W-1:0]};
    endfunction

    function automatic res_t alloc_block(input u64 sz);
        res_t r;
        int   order;
        int   cur;
        u64   hi;
        u64   idx;
        u64   blk;
        r = '0;
        if (sz == 0) sz = 1;
        order = floor_log2(sz);
        if ((sz & (sz - 1)) != 0) order++;
        if (order < PSHIFT) order = PSHIFT;
        if (order >= NORDERS)
        begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        hi = ord_mask & ~((64'd1 << order) - 1);
        if (hi == 0)
        begin
            r.status = ST_NO_BLOCK;
            return r;
        end
        cur = lowest_one(hi);
        idx = pop_block(cur);
        blk = page_addr(idx);
        while (cur > order)
        begin
            cur--;
            release_block(blk ^ (64'd1 << cur), cur);
        end
        pg_tag[idx]       = {1'b0, order[ORD_W-1:0]};
        r.status          = ST_DONE;
        r.granted_address = blk[ADDR_W-1:0];
        r.granted_order   = order[ORD_W-1:0];
        return r;
    endfunction

    function automatic res_t free_block(input u64 a);
        res_t           r;
        u64             idx;
        u64             bidx;
        u64             baddr;
        int             order;
        bit [TAG_W-1:0] t;
        bit [TAG_W-1:0] want;
        r = '0;
        r.status = ST_IGNORED;
        if (!page_index(a, idx)) return r;
        t = pg_tag[idx];
        if (t == 0 || t[FREE_POS]) return r;
        order = t[ORD_W-1:0];
        if (order >= NORDERS) return r;
        a = page_addr(idx);
        while (order + 1 < NORDERS)
        begin
            baddr = a ^ (64'd1 << order);
            if (!page_index(baddr, bidx)) break;
            want = {1'b1, order[ORD_W-1:0]};
            if (pg_tag[bidx] != want) break;
            if (!unlink_block(order, bidx)) break;
            if (baddr < a)
            begin
                pg_tag[idx] = 0;
                a   = baddr;
                idx = bidx;
            end
            else
                pg_tag[bidx] = 0;
            order++;
        end
        push_block(order, idx);
        pg_tag[idx]       = {1'b1, order[ORD_W-1:0]};
        r.status          = ST_DONE;
        r.granted_address = a[ADDR_W-1:0];
        r.granted_order   = order[ORD_W-1:0];
        return r;
    endfunction

    function automatic void carve_range(input u64 start, input u64 sz);
        u64 pool_lo;
        u64 end_pg;
        u64 n1;
        u64 n2;
        int so;
        int zo;
        int b;
        pool_lo = pool_base << PSHIFT;
        end_pg  = pool_base + tracked();
        while (sz >= (64'd1 << PSHIFT))
        begin
            so = lowest_one(start);
            zo = floor_log2(sz);
            b  = (so < zo) ? so : zo;
            if (b < PSHIFT)
            begin
                start += 64'd1 << b;
                sz    -= 64'd1 << b;
                continue;
            end
            if ((start >> PSHIFT) >= end_pg) break;
            if (b > NORDERS - 1) b = NORDERS - 1;
            // skip whole top-order blocks that lie below the pool
            if (b == NORDERS - 1 && start + (64'd1 << b) <= pool_lo)
            begin
                n1 = sz >> b;
                n2 = (pool_lo - start) >> b;
                if (n2 < n1) n1 = n2;
                start += n1 << b;
                sz    -= n1 << b;
                continue;
            end
            sz -= 64'd1 << b;
            release_block(start, b);
            start += 64'd1 << b;
        end
    endfunction

    function automatic res_t serve_request(input req_t q);
        res_t r;
        r = '0;
        case (q.req_type)
            REQ_ALLOC: r = alloc_block(u64'(q.byte_count));
            REQ_FREE:  r = free_block(u64'(q.block_address));
            REQ_ADD:   carve_range(u64'(q.block_address), u64'(q.byte_count));
            default:   r.status = ST_IGNORED;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------
    int stall_mode;
    int stall_left;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            res_t want;
            if (grant_q.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result st=%0d addr=%h ord=%0d",
                             out_item.status, out_item.granted_address,
                             out_item.granted_order);
                end
            end
            else
            begin
                want = grant_q.pop_front();
                if (out_item.status !== want.status ||
                    out_item.granted_address !== want.granted_address ||
                    out_item.granted_order !== want.granted_order)
                begin
                    errors++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("mismatch exp st=%0d addr=%h ord=%0d got st=%0d addr=%h ord=%0d",
                                 want.status, want.granted_address, want.granted_order,
                                 out_item.status, out_item.granted_address,
                                 out_item.granted_order);
                    end
                end
            end
        end
        // stall in stretches: none, coin flip, or mostly stalled
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 64);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("buddy_page_allocator_top_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks; each is entered and left at a rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input req_t q, input bit typed, input res_t typed_res);
        res_t r;
        in_valid <= 1'b1;
        in_item  <= q;
        do
            @(posedge clk);
        while (in_stall);
        r = serve_request(q);
        grant_q.push_back(typed ? typed_res : r);
        if (q.req_type == REQ_ALLOC && r.status == ST_DONE)
            held.push_back(u64'(r.granted_address));
        // bursts of back-to-back items, then a random gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    task automatic send_req(input logic [1:0] kind, input u64 cnt, input u64 a);
        req_t q;
        q.req_type      = kind;
        q.byte_count    = cnt[ADDR_W-1:0];
        q.block_address = a[ADDR_W-1:0];
        send_item(q, 1'b0, '0);
    endtask

    // pause until every result is back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (grant_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // raise the write strobe, then drop it and wait so that writes never share an edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input u64 val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == CFG_POOL_BASE)
            pool_base = val & 64'hF_FFFF_FFFF;
        else
            pool_count = val & 64'h1FFF;
    endtask

    task automatic set_pool(input u64 base, input u64 cnt);
        drain();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_COUNT, cnt);
        held.delete();
    endtask

    function automatic u64 rand64();
        return {$urandom, $urandom};
    endfunction

    // One setting of the pool: fill it, then mostly well-formed traffic.
    task automatic run_pool(input u64 base, input u64 cnt, input int n);
        u64 pool_lo;
        u64 span;
        u64 a;
        int pick;
        int k;
        set_pool(base, cnt);
        pool_lo = base << PSHIFT;
        span    = cnt << PSHIFT;
        send_req(REQ_ADD, span, pool_lo);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i == n / 2)
                drain();   // hold the sender until everything is back
            if (pick < 42)
                send_req(REQ_ALLOC, rand64() & ((64'd1 << $urandom_range(0, 22)) - 1), rand64());
            else if (pick < 77 && held.size() != 0)
            begin
                k = $urandom_range(0, held.size() - 1);
                a = held[k];
                held.delete(k);
                if ($urandom_range(0, 3) == 0)
                    a = a | $urandom_range(0, 4095);   // unaligned inside the page
                send_req(REQ_FREE, rand64(), a);
            end
            else if (pick < 85)
            begin
                // noise: a random address, or a held address with one bit flipped
                if (held.size() != 0 && $urandom_range(0, 1))
                    a = held[$urandom_range(0, held.size() - 1)] ^ (64'd1 << $urandom_range(0, 20));
                else
                    a = rand64();
                send_req(REQ_FREE, rand64(), a);
            end
            else if (pick < 92)
            begin
                a = pool_lo + (rand64() % (span + 4096));
                if ($urandom_range(0, 1)) a = a & ~64'hFFF;
                if ($urandom_range(0, 7) == 0) a = 0;
                send_req(REQ_ADD, rand64() % (span + 8192), a);
            end
            else if (pick < 97)
                send_req(REQ_ALLOC, rand64(), rand64());
            else
                send_req(2'd3, rand64(), rand64());
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        req_t q;
        bit   typed;
        res_t r;
    } row_t;

    row_t rows[$];

    function automatic void add_row(input logic [1:0] kind, input u64 cnt, input u64 a,
                                    input bit typed, input logic [1:0] st);
        row_t w;
        w.q.req_type      = kind;
        w.q.byte_count    = cnt[ADDR_W-1:0];
        w.q.block_address = a[ADDR_W-1:0];
        w.typed           = typed;
        w.r               = '0;
        w.r.status        = st;
        rows.push_back(w);
    endfunction

    localparam u64 ONES = 64'hFFFF_FFFF_FFFF;

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        errors     = 0;
        shown      = 0;
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        pool_base  = 0;
        pool_count = 0;
        ord_mask   = 0;
        for (int i = 0; i < NPAGES; i++)
        begin
            pg_tag[i]  = 0;
            pg_link[i] = 0;
        end
        for (int i = 0; i < NORDERS; i++) ord_head[i] = NPAGES;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);   // tag clearing pass

        // pool of 64 pages at pfn 0x10: byte range 0x10000..0x4ffff
        write_reg(CFG_POOL_BASE, 64'h10);
        write_reg(CFG_POOL_COUNT, 64);

        add_row(REQ_ALLOC, 0,               0,       1, ST_NO_BLOCK);   // empty pool
        add_row(REQ_ALLOC, ONES,            ONES,    1, ST_TOO_LARGE);
        add_row(REQ_ALLOC, 64'h8000_0000,   0,       1, ST_NO_BLOCK);   // top order
        add_row(REQ_ALLOC, 64'h1_0000_0000, 0,       1, ST_TOO_LARGE);  // one past
        add_row(REQ_FREE,  0,               0,       1, ST_IGNORED);    // below pool
        add_row(REQ_FREE,  ONES,            ONES,    1, ST_IGNORED);    // above pool
        add_row(2'd3,      ONES,            ONES,    1, ST_IGNORED);    // unknown kind
        add_row(REQ_ADD,   64'h4_0000,      64'h1_0000, 1, ST_DONE);
        add_row(REQ_ADD,   ONES,            0,       1, ST_DONE);       // start zero, huge
        add_row(REQ_FREE,  0,               64'h1_0000, 1, ST_IGNORED); // free but not held
        add_row(REQ_ALLOC, 0,               0,       0, ST_DONE);
        add_row(REQ_ALLOC, 4097,            0,       0, ST_DONE);
        add_row(REQ_ALLOC, 64'h2_0000,      0,       0, ST_DONE);
        add_row(REQ_ALLOC, 64'h4_0000,      0,       0, ST_DONE);
        add_row(REQ_FREE,  0,               64'h1_0123, 0, ST_DONE);    // unaligned
        add_row(REQ_FREE,  0,               64'h1_0000, 0, ST_DONE);    // double free
        add_row(REQ_FREE,  0,               64'h1_1000, 0, ST_DONE);
        add_row(REQ_FREE,  0,               64'h2_0000, 0, ST_DONE);
        add_row(REQ_ALLOC, 1,               0,       0, ST_DONE);
        add_row(REQ_ADD,   64'h1FFF,        64'h4_F001, 0, ST_DONE);    // sub-page tail
        foreach (rows[i])
            send_item(rows[i].q, rows[i].typed, rows[i].r);

        // random part across pool settings, extremes included
        run_pool(0,                        16,   300);
        run_pool(64'h10,                   64,   350);
        run_pool($urandom_range(0, 65535), 1,    150);
        run_pool(0,                        4096, 70);
        run_pool(64'hF_FFFF_FFFF,          4096, 60);
        run_pool(rand64() & 64'hF_FFFF_FFFF, 0,  100);
        run_pool(rand64() & 64'hF_FFFF,    8191, 70);
        run_pool(rand64() & 64'h3_FFFF,    300,  400);
        run_pool(rand64() & 64'hFFFF,      700,  300);

        drain();
        if (errors == 0 && grant_q.size() == 0)
            $display("buddy_page_allocator_top_tb OK");
        else
            $display("buddy_page_allocator_top_tb NOT OK");
        $finish;
    end

endmodule
